FILE: hw/rtl/oblagg_pkg.sv
package oblagg_pkg;

	localparam int ORDER_SLOTS = 1024;
	localparam int LEVEL_SLOTS = 256;
	localparam int BOOK_SLOTS  = 2 * LEVEL_SLOTS;
	localparam int OA_W        = $clog2(ORDER_SLOTS);
	localparam int LA_W        = $clog2(LEVEL_SLOTS);
	localparam int BA_W        = $clog2(BOOK_SLOTS);
	localparam int CLR_SLOTS   = (ORDER_SLOTS > BOOK_SLOTS) ? ORDER_SLOTS : BOOK_SLOTS;
	localparam int CNT_W       = $clog2(CLR_SLOTS) + 1;
	localparam int QTY_W       = 40;
	localparam int ORD_W       = 1 + 32 + 32;
	localparam int BOOK_W      = 1 + 32 + QTY_W;

	localparam logic [QTY_W-1:0] QTY_MAX = '1;

	localparam logic [2:0] SEL_BUY    = 3'd0;
	localparam logic [2:0] SEL_SELL   = 3'd1;
	localparam logic [2:0] SEL_BSTOP  = 3'd2;
	localparam logic [2:0] SEL_SSTOP  = 3'd3;
	localparam logic [2:0] SEL_TWOWAY = 3'd4;

	localparam logic [1:0] STAT_OPEN = 2'd0;
	localparam logic [1:0] STAT_PART = 2'd1;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ORD_FULL = 2'd1;
	localparam logic [1:0] ERR_LVL_FULL = 2'd2;
	localparam logic [1:0] ERR_LVL_MISS = 2'd3;

	typedef struct packed {
		logic [31:0]        ord_ref;
		logic [2:0]         side_sel;
		logic [1:0]         order_status;
		logic signed [31:0] order_price;
		logic [31:0]        remaining_qty;
		logic signed [31:0] buy_trigger;
		logic signed [31:0] sell_trigger;
	} order_in_t;

	typedef struct packed {
		logic               level_valid;
		logic               level_side;
		logic signed [31:0] level_price;
		logic [QTY_W-1:0]   level_qty;
		logic [1:0]         error_code;
	} level_out_t;

	typedef struct packed {
		logic used;
		logic [31:0] key;
		logic [31:0] left;
	} ord_word_t;

	typedef struct packed {
		logic used;
		logic [31:0] price;
		logic [QTY_W-1:0] qty;
	} book_word_t;

	typedef struct packed {
		logic       clr;
		logic       load;
		logic       cnt_clr;
		logic       scan_o;
		logic       scan_l;
		logic       odec;
		logic       calc;
		logic       commit;
		logic       emit_none;
		logic       emit_err;
		logic [1:0] err;
	} ctl_t;

	typedef struct packed {
		logic       clr_done;
		logic       drop;
		logic       scan_done;
		logic       ofound;
		logic       ofree;
		logic       qty_zero;
		logic       same;
		logic       lvl_ok;
		logic [1:0] lvl_err;
	} sts_t;

endpackage

FILE: hw/rtl/order_book_level_aggregator_top.sv
// channel   direction  handshake            payload
// update    in         start & !busy        req    (order_in_t)
// level     out        done, one cycle      result (level_out_t)
//
// a level change comes out after one pass over the order table and one over that side of the
// level table, one entry a cycle through each memory's registered read; a level error
// comes out of the level decision, without the write state. zero price or an unknown side:
// result from the check state, with no pass; a repeat, an empty new order or a full order
// table: result after the order-table pass only. busy drops in the cycle of done.
// after reset a clearing pass over the order table and the level table runs with busy high.
// the receiver cannot stall.
module order_book_level_aggregator_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  oblagg_pkg::order_in_t  req,
	output logic                   busy,
	output logic                   done,
	output oblagg_pkg::level_out_t result
);

	oblagg_pkg::ctl_t ctl;
	oblagg_pkg::sts_t st;

	oblagg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	oblagg_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.st     (st),
		.done   (done),
		.result (result)
	);

endmodule

FILE: hw/rtl/oblagg_ram.sv
module oblagg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/oblagg_ctrl.sv
module oblagg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  oblagg_pkg::sts_t   st,
	output oblagg_pkg::ctl_t   ctl,
	output logic               busy
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_OSCAN = 3'd3;
	localparam logic [2:0] S_ODEC  = 3'd4;
	localparam logic [2:0] S_LSCAN = 3'd5;
	localparam logic [2:0] S_LDEC  = 3'd6;
	localparam logic [2:0] S_WR    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		ctl = '0;
		nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				ctl.clr = 1'b1;
				if (st.clr_done) nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					nxt = S_CHK;
				end
			end
			S_CHK: begin
				if (st.drop) begin
					ctl.emit_none = 1'b1;
					nxt = S_IDLE;
				end else begin
					nxt = S_OSCAN;
				end
			end
			S_OSCAN: begin
				ctl.scan_o = 1'b1;
				if (st.scan_done) nxt = S_ODEC;
			end
			S_ODEC: begin
				ctl.odec = 1'b1;
				ctl.cnt_clr = 1'b1;
				priority if (!st.ofound && st.qty_zero) begin
					ctl.emit_none = 1'b1;
					nxt = S_IDLE;
				end else if (!st.ofound && !st.ofree) begin
					ctl.emit_err = 1'b1;
					ctl.err = oblagg_pkg::ERR_ORD_FULL;
					nxt = S_IDLE;
				end else if (st.ofound && st.same) begin
					ctl.emit_none = 1'b1;
					nxt = S_IDLE;
				end else begin
					nxt = S_LSCAN;
				end
			end
			S_LSCAN: begin
				ctl.scan_l = 1'b1;
				if (st.scan_done) nxt = S_LDEC;
			end
			S_LDEC: begin
				ctl.calc = 1'b1;
				if (st.lvl_ok) begin
					nxt = S_WR;
				end else begin
					ctl.emit_err = 1'b1;
					ctl.err = st.lvl_err;
					nxt = S_IDLE;
				end
			end
			S_WR: begin
				ctl.commit = 1'b1;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

`ifndef ASSERT_OFF
	a_commit_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> $past(state_q) == S_LDEC)
		else $error("commit without level decision");
	a_start_to_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> state_q == S_CHK)
		else $error("transfer not taken");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.emit_none, ctl.emit_err, ctl.commit}))
		else $error("two results in one cycle");
`endif

endmodule

FILE: hw/rtl/oblagg_dp.sv
module oblagg_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  oblagg_pkg::order_in_t  req,
	input  oblagg_pkg::ctl_t       ctl,
	output oblagg_pkg::sts_t       st,
	output logic                   done,
	output oblagg_pkg::level_out_t result
);

	localparam int OA_W  = oblagg_pkg::OA_W;
	localparam int LA_W  = oblagg_pkg::LA_W;
	localparam int BA_W  = oblagg_pkg::BA_W;
	localparam int CNT_W = oblagg_pkg::CNT_W;
	localparam int QTY_W = oblagg_pkg::QTY_W;

	oblagg_pkg::order_in_t  in_q;
	oblagg_pkg::ord_word_t  ord_rd, ord_wd;
	oblagg_pkg::book_word_t book_rd, book_wd;
	oblagg_pkg::level_out_t out_q;

	logic [CNT_W-1:0] cnt_q, limit, rd_idx_s1;
	logic             rd_vld_s1, rd_lvl_s1;
	logic             ofound_q, ofree_q, lfound_q, lfree_q;
	logic [OA_W-1:0]  oidx_q, ofidx_q;
	logic [LA_W-1:0]  lidx_q, lfidx_q;
	logic [31:0]      oleft_q;
	logic [QTY_W-1:0] lqty_q, d_q, newq_q;
	logic             add_q, done_q;

	logic             bid, ask, side;
	logic [31:0]      qty_eff;
	logic [BA_W-1:0]  bk_base;
	logic             ord_we, book_we;
	logic [OA_W-1:0]  ord_waddr, ord_raddr;
	logic [BA_W-1:0]  book_waddr, book_raddr;
	logic [QTY_W:0]   sum;
	logic [QTY_W-1:0] satq, base;

	assign bid = (in_q.side_sel == oblagg_pkg::SEL_BUY) ||
		(in_q.side_sel == oblagg_pkg::SEL_BSTOP) ||
		(in_q.side_sel == oblagg_pkg::SEL_TWOWAY && in_q.order_price >= in_q.buy_trigger);
	assign ask = (in_q.side_sel == oblagg_pkg::SEL_SELL) ||
		(in_q.side_sel == oblagg_pkg::SEL_SSTOP) ||
		(in_q.side_sel == oblagg_pkg::SEL_TWOWAY && in_q.order_price <= in_q.sell_trigger);
	assign side = !bid;
	assign qty_eff = (in_q.order_status == oblagg_pkg::STAT_OPEN ||
		in_q.order_status == oblagg_pkg::STAT_PART) ? in_q.remaining_qty : 32'd0;
	assign bk_base = side ? BA_W'(oblagg_pkg::LEVEL_SLOTS) : '0;
	assign limit = ctl.scan_o ? CNT_W'(oblagg_pkg::ORDER_SLOTS) :
		CNT_W'(oblagg_pkg::LEVEL_SLOTS);

	// new level value: add with saturation, or subtract on a reduction
	assign base = lfound_q ? lqty_q : '0;
	assign sum  = {1'b0, base} + {1'b0, d_q};
	assign satq = sum[QTY_W] ? oblagg_pkg::QTY_MAX : sum[QTY_W-1:0];

	always_comb begin
		st = '0;
		st.clr_done  = (cnt_q == CNT_W'(oblagg_pkg::CLR_SLOTS - 1));
		st.drop      = (in_q.order_price == 32'sd0) || !(bid || ask);
		st.scan_done = (cnt_q == limit) && !rd_vld_s1;
		st.ofound    = ofound_q;
		st.ofree     = ofree_q;
		st.qty_zero  = (qty_eff == 32'd0);
		st.same      = (oleft_q == qty_eff);
		st.lvl_ok    = add_q ? (lfound_q || lfree_q) : (lfound_q && lqty_q >= d_q);
		st.lvl_err   = add_q ? oblagg_pkg::ERR_LVL_FULL : oblagg_pkg::ERR_LVL_MISS;
	end

	always_comb begin
		ord_raddr  = cnt_q[OA_W-1:0];
		book_raddr = bk_base + BA_W'(cnt_q[LA_W-1:0]);
		ord_we     = 1'b0;
		book_we    = 1'b0;
		ord_waddr  = cnt_q[OA_W-1:0];
		book_waddr = cnt_q[BA_W-1:0];
		ord_wd     = '0;
		book_wd    = '0;
		if (ctl.clr) begin
			ord_we  = (cnt_q < CNT_W'(oblagg_pkg::ORDER_SLOTS));
			book_we = (cnt_q < CNT_W'(oblagg_pkg::BOOK_SLOTS));
		end else if (ctl.commit) begin
			ord_we       = 1'b1;
			book_we      = 1'b1;
			ord_waddr    = ofound_q ? oidx_q : ofidx_q;
			ord_wd.used  = (qty_eff != 32'd0);
			ord_wd.key   = in_q.ord_ref;
			ord_wd.left  = qty_eff;
			book_waddr   = bk_base + BA_W'(lfound_q ? lidx_q : lfidx_q);
			book_wd.used = (newq_q != '0);
			book_wd.price = in_q.order_price;
			book_wd.qty  = newq_q;
		end
	end

	oblagg_ram #(.WIDTH(oblagg_pkg::ORD_W), .DEPTH(oblagg_pkg::ORDER_SLOTS)) u_ord (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wd),
		.raddr (ord_raddr),
		.rdata (ord_rd)
	);

	oblagg_ram #(.WIDTH(oblagg_pkg::BOOK_W), .DEPTH(oblagg_pkg::BOOK_SLOTS)) u_book (
		.clk   (clk),
		.we    (book_we),
		.waddr (book_waddr),
		.wdata (book_wd),
		.raddr (book_raddr),
		.rdata (book_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (ctl.load || ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctl.clr || ((ctl.scan_o || ctl.scan_l) && cnt_q < limit)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= (ctl.scan_o || ctl.scan_l) && (cnt_q < limit);
			done_q    <= ctl.emit_none || ctl.emit_err || ctl.commit;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		rd_lvl_s1 <= ctl.scan_l;
		if (ctl.load) begin
			in_q     <= req;
			ofound_q <= 1'b0;
			ofree_q  <= 1'b0;
			lfound_q <= 1'b0;
			lfree_q  <= 1'b0;
		end else if (rd_vld_s1 && !rd_lvl_s1) begin
			if (ord_rd.used && ord_rd.key == in_q.ord_ref && !ofound_q) begin
				ofound_q <= 1'b1;
				oidx_q   <= rd_idx_s1[OA_W-1:0];
				oleft_q  <= ord_rd.left;
			end
			if (!ord_rd.used && !ofree_q) begin
				ofree_q <= 1'b1;
				ofidx_q <= rd_idx_s1[OA_W-1:0];
			end
		end else if (rd_vld_s1 && rd_lvl_s1) begin
			if (book_rd.used && book_rd.price == in_q.order_price && !lfound_q) begin
				lfound_q <= 1'b1;
				lidx_q   <= rd_idx_s1[LA_W-1:0];
				lqty_q   <= book_rd.qty;
			end
			if (!book_rd.used && !lfree_q) begin
				lfree_q <= 1'b1;
				lfidx_q <= rd_idx_s1[LA_W-1:0];
			end
		end
		if (ctl.odec) begin
			add_q <= !ofound_q || (qty_eff > oleft_q);
			if (!ofound_q) begin
				d_q <= QTY_W'(qty_eff);
			end else if (qty_eff > oleft_q) begin
				d_q <= QTY_W'(qty_eff - oleft_q);
			end else begin
				d_q <= QTY_W'(oleft_q - qty_eff);
			end
		end
		if (ctl.calc) begin
			newq_q <= add_q ? satq : (lqty_q - d_q);
		end
		if (ctl.emit_none) begin
			out_q <= '0;
		end else if (ctl.emit_err) begin
			out_q.level_valid <= 1'b0;
			out_q.level_side  <= 1'b0;
			out_q.level_price <= '0;
			out_q.level_qty   <= '0;
			out_q.error_code  <= ctl.err;
		end else if (ctl.commit) begin
			out_q.level_valid <= 1'b1;
			out_q.level_side  <= side;
			out_q.level_price <= in_q.order_price;
			out_q.level_qty   <= newq_q;
			out_q.error_code  <= oblagg_pkg::ERR_NONE;
		end
	end

	assign done   = done_q;
	assign result = out_q;

`ifndef ASSERT_OFF
	a_valid_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && out_q.level_valid) |-> out_q.error_code == oblagg_pkg::ERR_NONE)
		else $error("changed level reported with error");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result held more than one cycle");
	a_commit_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> ((lfound_q || lfree_q) && (ofound_q || ofree_q)))
		else $error("commit without slot");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ORDER_SLOTS = oblagg_pkg::ORDER_SLOTS;
	localparam int LEVEL_SLOTS = oblagg_pkg::LEVEL_SLOTS;
	localparam int BOOK_SLOTS  = oblagg_pkg::BOOK_SLOTS;
	localparam int QTY_W       = oblagg_pkg::QTY_W;
	localparam logic [2:0] SEL_OTHER  = 3'd5;
	localparam logic [2:0] SEL_UNUSED = 3'd7;
	localparam logic [1:0] STAT_FILLED = 2'd2;
	localparam logic [1:0] STAT_GONE   = 2'd3;
	localparam int QUIET_LIMIT = 20000;
	localparam int TAIL_CYCLES = ORDER_SLOTS + LEVEL_SLOTS + 64;

	typedef struct {
		oblagg_pkg::order_in_t upd;
		bit                    drain;
	} pending_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	oblagg_pkg::order_in_t  req = '0;
	logic                   busy;
	logic                   done;
	oblagg_pkg::level_out_t result;

	order_book_level_aggregator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the order table and the level book
	logic [31:0]      ord_key  [ORDER_SLOTS];
	logic [31:0]      ord_left [ORDER_SLOTS];
	bit               ord_used [ORDER_SLOTS];
	logic [31:0]      lvl_price[BOOK_SLOTS];
	logic [QTY_W-1:0] lvl_qty  [BOOK_SLOTS];
	bit               lvl_used [BOOK_SLOTS];

	pending_t               update_q[$];
	oblagg_pkg::level_out_t level_q[$];
	int total_updates, sent, received, failures, quiet;
	int err_seen[4];
	int level_changes;

	function automatic int find_level(int bs, logic [31:0] p);
		for (int i = bs * LEVEL_SLOTS; i < (bs + 1) * LEVEL_SLOTS; i++)
			if (lvl_used[i] && lvl_price[i] == p) return i;
		return -1;
	endfunction

	function automatic int claim_level(int bs, logic [31:0] p);
		int li;
		li = find_level(bs, p);
		if (li >= 0) return li;
		for (int i = bs * LEVEL_SLOTS; i < (bs + 1) * LEVEL_SLOTS; i++)
			if (!lvl_used[i]) begin
				lvl_used[i] = 1'b1;
				lvl_price[i] = p;
				lvl_qty[i] = '0;
				return i;
			end
		return -1;
	endfunction

	function automatic void add_level(int li, logic [31:0] d);
		logic [QTY_W:0] s;
		s = {1'b0, lvl_qty[li]} + (QTY_W + 1)'(d);
		lvl_qty[li] = s[QTY_W] ? oblagg_pkg::QTY_MAX : s[QTY_W-1:0];
	endfunction

	function automatic oblagg_pkg::level_out_t book_update(oblagg_pkg::order_in_t u);
		oblagg_pkg::level_out_t r;
		logic [31:0] q, old;
		logic [QTY_W-1:0] d;
		int bs, oi, fo, li;
		r = '0;
		oi = -1;
		fo = -1;
		if (u.order_price == 0) return r;
		q = u.remaining_qty;
		if (u.order_status != oblagg_pkg::STAT_OPEN && u.order_status != oblagg_pkg::STAT_PART)
			q = '0;
		if (u.side_sel == oblagg_pkg::SEL_BUY || u.side_sel == oblagg_pkg::SEL_BSTOP ||
		    (u.side_sel == oblagg_pkg::SEL_TWOWAY && u.order_price >= u.buy_trigger))
			bs = 0;
		else if (u.side_sel == oblagg_pkg::SEL_SELL || u.side_sel == oblagg_pkg::SEL_SSTOP ||
		         (u.side_sel == oblagg_pkg::SEL_TWOWAY && u.order_price <= u.sell_trigger))
			bs = 1;
		else
			return r;
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (oi < 0 && ord_used[i] && ord_key[i] == u.ord_ref) oi = i;
		if (oi < 0) begin
			if (q == 0) return r;
			for (int i = 0; i < ORDER_SLOTS; i++)
				if (fo < 0 && !ord_used[i]) fo = i;
			if (fo < 0) begin
				r.error_code = oblagg_pkg::ERR_ORD_FULL;
				return r;
			end
			li = claim_level(bs, u.order_price);
			if (li < 0) begin
				r.error_code = oblagg_pkg::ERR_LVL_FULL;
				return r;
			end
			ord_used[fo] = 1'b1;
			ord_key[fo] = u.ord_ref;
			ord_left[fo] = q;
			add_level(li, q);
		end else begin
			old = ord_left[oi];
			if (old == q) return r;
			if (q > old) begin
				li = claim_level(bs, u.order_price);
				if (li < 0) begin
					r.error_code = oblagg_pkg::ERR_LVL_FULL;
					return r;
				end
				add_level(li, q - old);
			end else begin
				d = QTY_W'(old - q);
				li = find_level(bs, u.order_price);
				if (li < 0 || lvl_qty[li] < d) begin
					r.error_code = oblagg_pkg::ERR_LVL_MISS;
					return r;
				end
				lvl_qty[li] = lvl_qty[li] - d;
				if (q == 0) ord_used[oi] = 1'b0;
			end
			ord_left[oi] = q;
		end
		r.level_valid = 1'b1;
		r.level_side = bs[0];
		r.level_price = u.order_price;
		r.level_qty = lvl_qty[li];
		if (lvl_qty[li] == 0) lvl_used[li] = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		failures++;
		$display("mismatch on result %0d: %s got %0h expected %0h", received, what, got, want);
	endtask

	function automatic bit sender_idles();
		if (sent < total_updates / 3) return $urandom_range(99) < 11;
		if (sent < 2 * total_updates / 3) return $urandom_range(99) < 47;
		return 1'b0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				level_q.push_back(book_update(req));
				sent++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (update_q.size() > 0 && !sender_idles() &&
			             !(update_q[0].drain && (level_q.size() > 0 || (start && !busy)))) begin
				start <= 1'b1;
				req <= update_q.pop_front().upd;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (level_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(result.level_qty), 64'd0);
			end else begin
				oblagg_pkg::level_out_t want;
				want = level_q.pop_front();
				if (result.level_valid !== want.level_valid)
					report_mismatch("level_valid", 64'(result.level_valid),
					                64'(want.level_valid));
				if (result.level_side !== want.level_side)
					report_mismatch("level_side", 64'(result.level_side), 64'(want.level_side));
				if (result.level_price !== want.level_price)
					report_mismatch("level_price", 64'(result.level_price),
					                64'(want.level_price));
				if (result.level_qty !== want.level_qty)
					report_mismatch("level_qty", 64'(result.level_qty), 64'(want.level_qty));
				if (result.error_code !== want.error_code)
					report_mismatch("error_code", 64'(result.error_code), 64'(want.error_code));
				err_seen[want.error_code]++;
				if (want.level_valid) level_changes++;
			end
			received++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n && !(start && !busy) && !done) quiet++;
		else quiet = 0;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("[order_book_level_aggregator_top] ERROR");
			$finish;
		end
	end

	task automatic push_update(logic [31:0] id, logic [2:0] sd, logic [1:0] st,
	                           logic [31:0] pr, logic [31:0] qty,
	                           logic [31:0] bt, logic [31:0] stg, bit drain);
		pending_t p;
		p.upd.ord_ref = id;
		p.upd.side_sel = sd;
		p.upd.order_status = st;
		p.upd.order_price = pr;
		p.upd.remaining_qty = qty;
		p.upd.buy_trigger = bt;
		p.upd.sell_trigger = stg;
		p.drain = drain;
		update_q.push_back(p);
	endtask

	task automatic push_random(bit wide);
		logic [31:0] id, pr, qty, bt, stg;
		logic [2:0] sd;
		logic [1:0] st;
		id = wide ? $urandom() : $urandom_range(39);
		sd = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
		st = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
		case ($urandom_range(9))
			0: pr = 0;
			1: pr = $urandom();
			default: pr = 32'($signed($urandom_range(24)) - 12);
		endcase
		qty = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(50);
		bt = ($urandom_range(3) == 0) ? $urandom() : pr + 32'($signed($urandom_range(6)) - 3);
		stg = ($urandom_range(3) == 0) ? $urandom() : pr + 32'($signed($urandom_range(6)) - 3);
		push_update(id, sd, st, pr, qty, bt, stg, 1'b0);
	endtask

	initial begin
		for (int i = 0; i < ORDER_SLOTS; i++) ord_used[i] = 1'b0;
		for (int i = 0; i < BOOK_SLOTS; i++) lvl_used[i] = 1'b0;

		// directed: sides, statuses, empty cases, errors, extremes
		push_update(32'd1, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'd100, 32'd10,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd2, oblagg_pkg::SEL_SELL, oblagg_pkg::STAT_PART, 32'd100, 32'd5,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd3, oblagg_pkg::SEL_BSTOP, oblagg_pkg::STAT_OPEN, 32'd100, 32'd7,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd4, oblagg_pkg::SEL_SSTOP, oblagg_pkg::STAT_OPEN, 32'd300, 32'd1,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd5, oblagg_pkg::SEL_TWOWAY, oblagg_pkg::STAT_OPEN, 32'd50, 32'd3,
		            32'd50, 32'd10, 1'b0);
		push_update(32'd6, oblagg_pkg::SEL_TWOWAY, oblagg_pkg::STAT_OPEN, 32'd50, 32'd3,
		            32'd60, 32'd50, 1'b0);
		push_update(32'd7, oblagg_pkg::SEL_TWOWAY, oblagg_pkg::STAT_OPEN, 32'd50, 32'd3,
		            32'd60, 32'd40, 1'b0);
		push_update(32'd8, SEL_OTHER, oblagg_pkg::STAT_OPEN, 32'd50, 32'd3, 32'd0, 32'd0, 1'b0);
		push_update(32'd9, SEL_UNUSED, oblagg_pkg::STAT_OPEN, 32'd50, 32'd3, 32'd0, 32'd0, 1'b0);
		push_update(32'd1, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'd0, 32'd99,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd10, oblagg_pkg::SEL_BUY, STAT_FILLED, 32'd100, 32'd10,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd1, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'd100, 32'd10,
		            32'd0, 32'd0, 1'b1);
		push_update(32'd1, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_PART, 32'd100, 32'd4,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd1, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'd100, 32'd20,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd1, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'd200, 32'd2,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd2, oblagg_pkg::SEL_SELL, oblagg_pkg::STAT_OPEN, 32'd300, 32'd0,
		            32'd0, 32'd0, 1'b0);
		push_update(32'd2, oblagg_pkg::SEL_SELL, STAT_GONE, 32'd100, 32'd9, 32'd0, 32'd0, 1'b0);
		push_update(32'd0, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'h8000_0000,
		            32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		push_update(32'hFFFF_FFFF, oblagg_pkg::SEL_TWOWAY, oblagg_pkg::STAT_OPEN, 32'h7FFF_FFFF,
		            32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		push_update(32'h0000_0000, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN, 32'h8000_0000,
		            32'd1, 32'd0, 32'd0, 1'b0);
		push_update(32'hFFFF_FFFF, oblagg_pkg::SEL_TWOWAY, STAT_FILLED, 32'h7FFF_FFFF, 32'd5,
		            32'h8000_0000, 32'h7FFF_FFFF, 1'b0);

		// mixed traffic on a small pool of ids and prices
		for (int i = 0; i < 200; i++) push_random($urandom_range(9) == 0);
		// fill: distinct bid prices exhaust the bid side, large ask orders
		// pile up on one level, and the order table runs full
		for (int i = 0; i < 1000; i++) begin
			if (i % 4 == 0)
				push_update(32'h1000 + i, oblagg_pkg::SEL_BUY, oblagg_pkg::STAT_OPEN,
				            32'd1000 + i, $urandom_range(1, 100), 32'd0, 32'd0, i == 500);
			else if (i % 4 == 1)
				push_update(32'h1000 + i, oblagg_pkg::SEL_SELL, oblagg_pkg::STAT_OPEN, 32'd7,
				            32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
			else
				push_update(32'h1000 + i, oblagg_pkg::SEL_SSTOP, oblagg_pkg::STAT_PART,
				            32'($urandom_range(1, 20)), $urandom_range(1, 1000),
				            32'd0, 32'd0, 1'b0);
		end
		// reductions and closures against the full tables
		for (int i = 0; i < 80; i++) begin
			if (i % 2 == 0)
				push_update(32'h1000 + 4 * i + 1, oblagg_pkg::SEL_SELL, 2'($urandom_range(3)),
				            32'd7, $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom(),
				            32'd0, 32'd0, 1'b0);
			else
				push_random(1'b0);
		end
		total_updates = update_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent == total_updates && level_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d updates, %0d results, %0d level changes", sent, received, level_changes);
		$display("errors seen: order full %0d, level full %0d, missing/underflow %0d",
		         err_seen[oblagg_pkg::ERR_ORD_FULL], err_seen[oblagg_pkg::ERR_LVL_FULL],
		         err_seen[oblagg_pkg::ERR_LVL_MISS]);
		if (failures == 0 && level_q.size() == 0)
			$display("[order_book_level_aggregator_top] OK");
		else
			$display("[order_book_level_aggregator_top] ERROR");
		$finish;
	end
endmodule

FILE: order_book_level_aggregator_top.f
hw/rtl/oblagg_pkg.sv
hw/rtl/oblagg_ram.sv
hw/rtl/oblagg_ctrl.sv
hw/rtl/oblagg_dp.sv
hw/rtl/order_book_level_aggregator_top.sv
tb/tb_top.sv
